// ===== rtl/core/seven_segment_scan_driver_core_defines.svh =====
// Assertion macros shared by the seven-segment scan driver core.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SSSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seven segment scan driver check failed");
`define SSSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seven segment scan driver check failed");
`else
`define SSSD_ASSERT_NOW(label, ante, cons)
`define SSSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/sssd_pkg.sv =====
// Shared types, constants and the segment table of the seven-segment scan driver.
// Used by every module of the core; depends on nothing else.
package sssd_pkg;

    localparam int DIGITS = 8;
    localparam int MAX_CHARS_DEFAULT = 16;

    localparam logic [1:0] CFG_TEXT_FIRST = 2'd0;
    localparam logic [1:0] CFG_TEXT_LAST  = 2'd1;
    localparam logic [1:0] CFG_START_POS  = 2'd2;

    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    localparam logic [7:0] SEG_TABLE [30] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
        8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
        8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79,
        8'h71, 8'h76, 8'h30, 8'h0e, 8'h38,
        8'h54, 8'h3f, 8'h73, 8'h67, 8'h50,
        8'h6d, 8'h3e, 8'h3e, 8'h6e, 8'h40
    };

    typedef struct packed {
        logic       frame_end;
        logic       digit_driven;
        logic [7:0] segments;
        logic [2:0] digit_select;
    } sssd_result_t;

endpackage

// ===== rtl/core/seven_segment_scan_driver_core.sv =====
// Seven-segment scan driver core: configuration registers, input and result registers.
// Depends on sssd_pkg, sssd_scan_state and the assertion macro header.
// A tick is held in the input register, and its result then in the result register, which offers it.
// Throughput: one tick per cycle while m_tready is high; the result register frees as its content transfers.
// Reset clears the scan state and point marks, the text to zeros and the start position to 1.
// Configuration writes are taken in every cycle and need no clearing pass.
`include "seven_segment_scan_driver_core_defines.svh"
module seven_segment_scan_driver_core
    import sssd_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // bit 0: tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // bits 2:0 digit_select, 10:3 segments
    output logic        m_tuser,    // bit 0: digit_driven
    output logic        m_tlast,    // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]  text_first_reg;
    logic [63:0]  text_last_reg;
    logic [3:0]   start_pos_reg;
    logic         in_valid_reg;
    logic         in_valid_next;
    logic         in_tick_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    sssd_result_t out_data_reg;
    sssd_result_t step_result;
    logic         advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_first_reg <= '0;
            text_last_reg  <= '0;
            start_pos_reg  <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEXT_FIRST: text_first_reg <= cfg_data;
                CFG_TEXT_LAST:  text_last_reg  <= cfg_data;
                CFG_START_POS:  start_pos_reg  <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    sssd_scan_state #(
        .MAX_CHARS (MAX_CHARS)
    ) u_scan_state (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .tick             (in_tick_reg),
        .text_first_eight (text_first_reg),
        .text_last_eight  (text_last_reg),
        .start_position   (start_pos_reg),
        .result           (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_tick_reg <= s_tdata[0];
        end
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_data_reg.segments, out_data_reg.digit_select};
    assign m_tuser  = out_data_reg.digit_driven;
    assign m_tlast  = out_data_reg.frame_end;

    `SSSD_ASSERT_NOW(a_skip_is_blank, m_tvalid && !m_tuser, m_tdata[10:0] == 11'd0)
    `SSSD_ASSERT_NOW(a_stall_blocks_input, in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `SSSD_ASSERT_NEXT(a_advance_fills_output, advance, m_tvalid)

endmodule

// ===== rtl/core/sssd_char_decode.sv =====
// Case-insensitive ASCII to seven-segment decoder.
// Depends on sssd_pkg for the segment table.
module sssd_char_decode
    import sssd_pkg::*;
(
    input  logic [7:0] char_code,
    output logic [7:0] segments
);

    logic [7:0] upper_code;
    logic [7:0] digit_offset;

    assign digit_offset = char_code - 8'h30;

    always_comb
    begin
        if (char_code >= "a" && char_code <= "z")
        begin
            upper_code = char_code - 8'h20;
        end
        else
        begin
            upper_code = char_code;
        end
    end

    always_comb
    begin
        if (char_code >= "0" && char_code <= "9")
        begin
            segments = SEG_TABLE[5'(digit_offset)];
        end
        else
        begin
            case (upper_code)
                "A":     segments = SEG_TABLE[10];
                "B":     segments = SEG_TABLE[11];
                "C":     segments = SEG_TABLE[12];
                "D":     segments = SEG_TABLE[13];
                "E":     segments = SEG_TABLE[14];
                "F":     segments = SEG_TABLE[15];
                "H":     segments = SEG_TABLE[16];
                "I":     segments = SEG_TABLE[17];
                "J":     segments = SEG_TABLE[18];
                "L":     segments = SEG_TABLE[19];
                "N":     segments = SEG_TABLE[20];
                "O":     segments = SEG_TABLE[21];
                "P":     segments = SEG_TABLE[22];
                "Q":     segments = SEG_TABLE[23];
                "R":     segments = SEG_TABLE[24];
                "S":     segments = SEG_TABLE[25];
                "U":     segments = SEG_TABLE[26];
                "V":     segments = SEG_TABLE[27];
                "Y":     segments = SEG_TABLE[28];
                "-":     segments = SEG_TABLE[29];
                default: segments = SEG_BLANK;
            endcase
        end
    end

endmodule

// ===== rtl/core/sssd_scan_state.sv =====
// Scan state of the driver: character index, point count and point marks, with the
// per-tick step logic. Depends on sssd_pkg and sssd_char_decode.
module sssd_scan_state
    import sssd_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         tick,
    input  logic [63:0]  text_first_eight,
    input  logic [63:0]  text_last_eight,
    input  logic [3:0]   start_position,
    output sssd_result_t result
);

    localparam int IDX_W = $clog2(MAX_CHARS);

    logic [IDX_W-1:0]     char_index_reg;
    logic [IDX_W-1:0]     char_index_next;
    logic [3:0]           point_count_reg;
    logic [3:0]           point_count_next;
    logic [MAX_CHARS-1:0] point_marks_reg;
    logic [MAX_CHARS-1:0] point_marks_next;

    logic [127:0] text_all;
    logic [3:0]   index_wide;
    logic [7:0]   char_code;
    logic [7:0]   decoded;
    logic         last_slot;
    logic         is_point;
    logic [5:0]   position;
    logic         finish;

    assign text_all   = {text_last_eight, text_first_eight};
    assign index_wide = 4'(char_index_reg);
    assign char_code  = text_all[{index_wide, 3'b000} +: 8];
    assign last_slot  = (char_index_reg == IDX_W'(MAX_CHARS - 1));
    assign is_point   = (char_code == ".");
    assign position   = {2'b00, start_position} + {2'b00, index_wide} - {2'b00, point_count_reg};

    sssd_char_decode u_decode (
        .char_code (char_code),
        .segments  (decoded)
    );

    always_comb
    begin
        result           = '0;
        char_index_next  = char_index_reg;
        point_count_next = point_count_reg;
        point_marks_next = point_marks_reg;
        finish           = 1'b0;
        if (tick)
        begin
            if (is_point)
            begin
                if (char_index_reg != '0)
                begin
                    point_marks_next[char_index_reg - 1'b1] = 1'b1;
                end
                if (point_count_reg != 4'hf)
                begin
                    point_count_next = point_count_reg + 4'd1;
                end
                finish = last_slot;
            end
            else
            begin
                result.digit_select = 3'(DIGITS) - position[2:0];
                result.segments     = decoded | (point_marks_reg[char_index_reg] ? SEG_POINT
                                                                                 : SEG_BLANK);
                result.digit_driven = 1'b1;
                finish = (position == 6'(DIGITS)) || (char_code == 8'h00) || last_slot;
                if (finish && point_count_reg == 4'd0)
                begin
                    point_marks_next = '0;
                end
            end
            result.frame_end = finish;
            if (finish)
            begin
                char_index_next  = '0;
                point_count_next = 4'd0;
            end
            else
            begin
                char_index_next = char_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_index_reg  <= '0;
            point_count_reg <= 4'd0;
            point_marks_reg <= '0;
        end
        else if (step)
        begin
            char_index_reg  <= char_index_next;
            point_count_reg <= point_count_next;
            point_marks_reg <= point_marks_next;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for seven_segment_scan_driver_core: text and start position writes,
// random refresh ticks and an in-bench scan predictor that checks every result transfer.
// Depends on sssd_pkg and the core RTL only.
module testbench;
    import sssd_pkg::*;

    localparam logic [7:0] CHAR_DOT = 8'h2e;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };
    localparam int TICK_TARGET = 1450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_TEXT_FIRST;
    logic [63:0] cfg_data = '0;

    // Predicted scan state and register copies.
    logic [63:0] text_lo = '0;
    logic [63:0] text_hi = '0;
    logic [3:0]  start_pos = 4'd1;
    logic [3:0]  scan_idx = '0;
    logic [3:0]  point_cnt = '0;
    logic [15:0] point_mark = '0;

    bit           tick_queue [$];
    sssd_result_t results_due [$];

    int src_gap = 0;
    int snk_gap = 0;
    bit src_steady = 1'b0;
    bit snk_steady = 1'b0;
    int long_hold = 0;
    int err_count = 0;
    int ticks_total = 0;
    int results_seen = 0;
    int frames_seen = 0;
    int lit_points = 0;
    int settings_used = 0;

    always #5 clk = ~clk;

    seven_segment_scan_driver_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] char_segments(input logic [7:0] c);
        logic [7:0] u;
        if (c >= "0" && c <= "9")
            return DIGIT_SEGS[c - CHAR_ZERO];
        u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
        case (u)
            "A": return 8'h77;
            "B": return 8'h7c;
            "C": return 8'h58;
            "D": return 8'h5e;
            "E": return 8'h79;
            "F": return 8'h71;
            "H": return 8'h76;
            "I": return 8'h30;
            "J": return 8'h0e;
            "L": return 8'h38;
            "N": return 8'h54;
            "O": return 8'h3f;
            "P": return 8'h73;
            "Q": return 8'h67;
            "R": return 8'h50;
            "S": return 8'h6d;
            "U": return 8'h3e;
            "V": return 8'h3e;
            "Y": return 8'h6e;
            "-": return 8'h40;
            default: return SEG_BLANK;
        endcase
    endfunction

    function automatic logic [7:0] text_char(input logic [3:0] idx);
        if (idx < 4'd8)
            return text_lo[8 * int'(idx) +: 8];
        return text_hi[8 * (int'(idx) - 8) +: 8];
    endfunction

    function automatic void close_frame();
        scan_idx = '0;
        if (point_cnt != 0)
            point_cnt = '0;
        else
            point_mark = '0;
    endfunction

    function automatic sssd_result_t scan_tick(input logic tick);
        sssd_result_t r;
        logic [3:0]   idx;
        logic [7:0]   c;
        int           pos;
        bit           last_slot;
        r = '0;
        if (!tick)
            return r;
        idx = scan_idx;
        last_slot = (idx == 4'd15);
        c = text_char(idx);
        if (c == CHAR_DOT)
        begin
            if (idx != 0)
                point_mark[idx - 4'd1] = 1'b1;
            if (point_cnt != 4'd15)
                point_cnt = point_cnt + 4'd1;
            if (last_slot)
            begin
                close_frame();
                r.frame_end = 1'b1;
            end
            else
                scan_idx = idx + 4'd1;
            return r;
        end
        pos = int'(start_pos) + int'(idx) - int'(point_cnt);
        r.segments = char_segments(c) | (point_mark[idx] ? SEG_POINT : SEG_BLANK);
        r.digit_select = 3'(DIGITS - pos);
        r.digit_driven = 1'b1;
        if (pos == DIGITS || c == CHAR_NUL || last_slot)
        begin
            close_frame();
            r.frame_end = 1'b1;
        end
        else
            scan_idx = idx + 4'd1;
        return r;
    endfunction

    function automatic logic [7:0] random_char();
        string keys;
        keys = "ABCDEFHIJLNOPQRSUVY-";
        case ($urandom_range(0, 9))
            0, 1, 2: return CHAR_ZERO + 8'($urandom_range(0, 9));
            3, 4:    return keys[$urandom_range(0, 19)];
            5:       return keys[$urandom_range(0, 18)] + 8'h20;
            6, 8:    return CHAR_DOT;
            7:       return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [127:0] pack_text(input string s);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 16; i++)
            r[8 * i +: 8] = s[i];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TEXT_FIRST: text_lo = val;
            CFG_TEXT_LAST:  text_hi = val;
            CFG_START_POS:  start_pos = val[3:0];
            default: ;
        endcase
    endtask

    task automatic write_setting(input logic [127:0] txt, input logic [3:0] first_pos);
        write_reg(CFG_TEXT_FIRST, txt[63:0]);
        write_reg(CFG_TEXT_LAST, txt[127:64]);
        write_reg(CFG_START_POS, {60'd0, first_pos});
        settings_used++;
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            tick_queue.push_back($urandom_range(0, 9) != 0);
        ticks_total += n;
    endtask

    task automatic wait_drained();
        while (tick_queue.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                results_due.push_back(scan_tick(s_tdata[0]));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    src_gap <= src_gap - 1;
                end
                else if (tick_queue.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, tick_queue.pop_front()};
                    src_gap <= src_steady ? 0 : pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin : check_transfer
                sssd_result_t want;
                results_seen++;
                if (m_tlast)
                    frames_seen++;
                if (m_tdata[10])
                    lit_points++;
                if (results_due.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = results_due.pop_front();
                    if (m_tdata[2:0] !== want.digit_select)
                        report_mismatch($sformatf("digit_select %0d, expected %0d",
                            m_tdata[2:0], want.digit_select));
                    if (m_tdata[10:3] !== want.segments)
                        report_mismatch($sformatf("segments %02h, expected %02h",
                            m_tdata[10:3], want.segments));
                    if (m_tuser !== want.digit_driven)
                        report_mismatch($sformatf("digit_driven %b, expected %b",
                            m_tuser, want.digit_driven));
                    if (m_tlast !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b",
                            m_tlast, want.frame_end));
                end
            end
            if (long_hold > 0)
            begin
                m_tready <= 1'b0;
                long_hold <= long_hold - 1;
            end
            else if (snk_gap > 0)
            begin
                m_tready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!snk_steady && $urandom_range(0, 3) == 0)
                    snk_gap <= pick_gap();
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        logic [127:0] txt;
        logic [3:0]   first_pos;
        int           phase;
        int           n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset text is all NUL: every driven tick ends the frame; an idle tick in between.
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        ticks_total += 3;
        wait_idle();

        // Leading point marks nothing; the next point lights the digit before it next frame.
        write_setting(pack_text(".8.-"), 4'd7);
        for (int i = 0; i < 7; i++)
            tick_queue.push_back(i != 2);
        ticks_total += 7;
        wait_idle();

        // Sixteen points: the count saturates and the last slot closes the frame.
        write_setting(pack_text("................"), 4'd8);
        for (int i = 0; i < 16; i++)
            tick_queue.push_back(1'b1);
        ticks_total += 16;
        wait_idle();

        phase = 0;
        while (ticks_total < TICK_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: txt = '1;
                1: txt = '0;
                default:
                begin
                    for (int i = 0; i < 16; i++)
                        txt[8 * i +: 8] = random_char();
                    if ($urandom_range(0, 2) == 0)
                        txt[8 * $urandom_range(1, 15) +: 8] = CHAR_NUL;
                end
            endcase
            if (phase == 0)
                first_pos = 4'd1;
            else if (phase == 1)
                first_pos = 4'd8;
            else if (phase == 3)
                first_pos = 4'd0;
            else if (phase == 5)
                first_pos = 4'd15;
            else if ($urandom_range(0, 9) == 0)
                first_pos = 4'($urandom_range(9, 15));
            else
                first_pos = 4'($urandom_range(1, 8));
            write_setting(txt, first_pos);
            src_steady <= ($urandom_range(0, 3) == 0);
            snk_steady <= ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 70);
            if (phase == 2)
            begin
                src_steady <= 1'b1;
                long_hold <= 300;
                n = 80;
            end
            if (phase == 4)
            begin
                push_ticks(n / 2);
                wait_drained();
                n = n - n / 2;
            end
            push_ticks(n);
            wait_idle();
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        $display("Run covered %0d ticks over %0d text and start settings, %0d frames ended.",
            ticks_total, settings_used, frames_seen);
        $display("%0d results checked, %0d with a lit point, %0d mismatches.",
            results_seen, lit_points, err_count);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sssd_pkg.sv
rtl/core/sssd_char_decode.sv
rtl/core/sssd_scan_state.sv
rtl/core/seven_segment_scan_driver_core.sv
tb/testbench.sv
